@@ src/lcdde_pkg.sv @@
// Package for the LCD draw command byte engine.
// Holds opcodes, sequencer phases, command bytes, job records and the 5x7 font table.
// No dependencies.
package lcdde_pkg;

  localparam int DEF_SCREEN_WIDTH  = 240;
  localparam int DEF_SCREEN_HEIGHT = 320;
  localparam int LEN_W   = 13;
  localparam int PIX_W   = 2 * LEN_W;
  localparam int NPARTS  = 40;
  localparam int PART_W  = 6;

  localparam logic [7:0] CMD_COL_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR  = 8'h2C;
  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam logic [7:0] GLYPH_LAST  = 8'd96;

  typedef enum logic [2:0] {
    OP_PULL   = 3'd0,
    OP_PIXEL  = 3'd1,
    OP_FILL   = 3'd2,
    OP_GLYPH  = 3'd3,
    OP_SCALED = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXELS
  } phase_t;

  typedef enum logic [3:0] {
    HB_COL_CMD = 4'd0,
    HB_CS_HI   = 4'd1,
    HB_CS_LO   = 4'd2,
    HB_CE_HI   = 4'd3,
    HB_CE_LO   = 4'd4,
    HB_ROW_CMD = 4'd5,
    HB_RS_HI   = 4'd6,
    HB_RS_LO   = 4'd7,
    HB_RE_HI   = 4'd8,
    HB_RE_LO   = 4'd9,
    HB_WR_CMD  = 4'd10
  } hdr_pos_t;

  typedef struct packed {
    logic [15:0]      start;
    logic [15:0]      stop;
    logic [LEN_W-1:0] len;
  } span_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [NPARTS-1:0]  latch;
    logic [7:0]         colen;
    logic [7:0]         rowen;
    logic [7:0][15:0]   xs;
    logic [7:0][15:0]   ys;
    logic [15:0]        wsize;
    logic [15:0]        hsize;
    logic [15:0]        fg;
    logic [15:0]        bg;
  } pre_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [NPARTS-1:0] latch;
    logic [NPARTS-1:0] vis;
    logic [15:0]       fg;
    logic [15:0]       bg;
    span_t [7:0]       cols;
    span_t [7:0]       rows;
  } job_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_data;
    logic       byte_valid;
    logic       cmd_accepted;
    logic       busy;
  } res_t;

  function automatic logic [39:0] glyph_bits(logic [6:0] idx);
    logic [39:0] g;
    unique case (idx)
      7'd0:  g = 40'h0000000000; 7'd1:  g = 40'h00005F0000; 7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147F147F14; 7'd4:  g = 40'h122A7F2A24; 7'd5:  g = 40'h6264081323;
      7'd6:  g = 40'h5022554936; 7'd7:  g = 40'h0000030500; 7'd8:  g = 40'h0041221C00;
      7'd9:  g = 40'h001C224100; 7'd10: g = 40'h14083E0814; 7'd11: g = 40'h08083E0808;
      7'd12: g = 40'h0000305000; 7'd13: g = 40'h0808080808; 7'd14: g = 40'h0000606000;
      7'd15: g = 40'h0204081020; 7'd16: g = 40'h3E4549513E; 7'd17: g = 40'h00407F4200;
      7'd18: g = 40'h4649516142; 7'd19: g = 40'h314B454121; 7'd20: g = 40'h107F121418;
      7'd21: g = 40'h3945454527; 7'd22: g = 40'h3049494A3C; 7'd23: g = 40'h0305097101;
      7'd24: g = 40'h3649494936; 7'd25: g = 40'h1E29494906; 7'd26: g = 40'h0000363600;
      7'd27: g = 40'h0000365600; 7'd28: g = 40'h0041221408; 7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0814224100; 7'd31: g = 40'h0609510102; 7'd32: g = 40'h3E41794932;
      7'd33: g = 40'h7E1111117E; 7'd34: g = 40'h364949497F; 7'd35: g = 40'h224141413E;
      7'd36: g = 40'h1C2241417F; 7'd37: g = 40'h414949497F; 7'd38: g = 40'h010909097F;
      7'd39: g = 40'h7A4949413E; 7'd40: g = 40'h7F0808087F; 7'd41: g = 40'h00417F4100;
      7'd42: g = 40'h013F414020; 7'd43: g = 40'h412214087F; 7'd44: g = 40'h404040407F;
      7'd45: g = 40'h7F020C027F; 7'd46: g = 40'h7F1008047F; 7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h060909097F; 7'd49: g = 40'h5E2151413E; 7'd50: g = 40'h462919097F;
      7'd51: g = 40'h3149494946; 7'd52: g = 40'h01017F0101; 7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F; 7'd55: g = 40'h3F4038403F; 7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807; 7'd58: g = 40'h4345495161; 7'd59: g = 40'h0041417F00;
      7'd60: g = 40'h2010080402; 7'd61: g = 40'h007F414100; 7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040; 7'd64: g = 40'h0004020100;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

@@ src/lcdde_front.sv @@
// Front end: takes requests, looks up glyphs and clips every part of a command.
// Two register stages; depends on lcdde_pkg.
module lcdde_front import lcdde_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [15:0] in_rect_width,
  input  logic [15:0] in_rect_height,
  input  logic [7:0]  in_glyph_code,
  input  logic [15:0] in_fore_color,
  input  logic [15:0] in_back_color,
  input  logic [7:0]  in_glyph_scale,
  output logic        push,
  output job_t        push_job,
  input  logic        q_full
);

  localparam logic [16:0] SW = 17'(SCREEN_WIDTH);
  localparam logic [16:0] SH = 17'(SCREEN_HEIGHT);

  logic  s1_valid_r, s1_valid_nxt, s2_valid_r, s2_valid_nxt;
  logic  s2_take, in_take;
  pre_t  pre_nxt, s1_r;
  job_t  job_nxt, s2_r;
  logic  [7:0] step;
  logic  code_ok;
  logic  [7:0] colvis, rowvis;
  logic  [16:0] sum;
  logic  [15:0] len16;

  assign push     = s2_valid_r & ~q_full;
  assign s2_take  = ~s2_valid_r | ~q_full;
  assign in_stall = s1_valid_r & ~s2_take;
  assign in_take  = in_valid & ~in_stall;
  assign push_job = s2_r;

  always_comb begin
    code_ok = (in_glyph_code >= GLYPH_FIRST) && (in_glyph_code <= GLYPH_LAST);
    pre_nxt = '0;
    pre_nxt.op = in_opcode;
    pre_nxt.fg = in_fore_color;
    pre_nxt.bg = in_back_color;
    step = 8'd0;
    if (in_opcode == OP_PIXEL || in_opcode == OP_FILL) begin
      pre_nxt.latch = '1;
      pre_nxt.colen = 8'h01;
      pre_nxt.rowen = 8'h01;
      pre_nxt.wsize = (in_opcode == OP_PIXEL) ? 16'd1 : in_rect_width;
      pre_nxt.hsize = (in_opcode == OP_PIXEL) ? 16'd1 : in_rect_height;
    end else begin
      pre_nxt.latch = glyph_bits(7'(in_glyph_code - GLYPH_FIRST));
      pre_nxt.colen = code_ok ? 8'h1F : 8'h00;
      pre_nxt.rowen = (in_opcode == OP_GLYPH) ? 8'hFF : 8'h7F;
      step          = (in_opcode == OP_GLYPH) ? 8'd1 : in_glyph_scale;
      pre_nxt.wsize = {8'd0, step};
      pre_nxt.hsize = {8'd0, step};
    end
    for (int i = 0; i < 8; i++) begin
      pre_nxt.xs[i] = in_pos_x + 16'(i) * {8'd0, step};
      pre_nxt.ys[i] = in_pos_y + 16'(i) * {8'd0, step};
    end
  end

  always_comb begin
    job_nxt = '0;
    job_nxt.op    = s1_r.op;
    job_nxt.latch = s1_r.latch;
    job_nxt.fg    = s1_r.fg;
    job_nxt.bg    = s1_r.bg;
    sum = '0;
    len16 = '0;
    for (int i = 0; i < 8; i++) begin
      colvis[i] = s1_r.colen[i] & ({1'b0, s1_r.xs[i]} < SW);
      sum = {1'b0, s1_r.xs[i]} + {1'b0, s1_r.wsize};
      len16 = (sum > SW) ? 16'(SW - {1'b0, s1_r.xs[i]}) : s1_r.wsize;
      job_nxt.cols[i].start = s1_r.xs[i];
      job_nxt.cols[i].stop  = s1_r.xs[i] + len16 - 16'd1;
      job_nxt.cols[i].len   = len16[LEN_W-1:0];
      rowvis[i] = s1_r.rowen[i] & ({1'b0, s1_r.ys[i]} < SH);
      sum = {1'b0, s1_r.ys[i]} + {1'b0, s1_r.hsize};
      len16 = (sum > SH) ? 16'(SH - {1'b0, s1_r.ys[i]}) : s1_r.hsize;
      job_nxt.rows[i].start = s1_r.ys[i];
      job_nxt.rows[i].stop  = s1_r.ys[i] + len16 - 16'd1;
      job_nxt.rows[i].len   = len16[LEN_W-1:0];
    end
    for (int c = 0; c < 5; c++) begin
      for (int r = 0; r < 8; r++) begin
        job_nxt.vis[c*8+r] = colvis[c] & rowvis[r];
      end
    end
  end

  assign s1_valid_nxt = in_take | (s1_valid_r & ~s2_take);
  assign s2_valid_nxt = (s1_valid_r & s2_take) | (s2_valid_r & ~s2_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= pre_nxt;
    end
    if (s1_valid_r && s2_take) begin
      s2_r <= job_nxt;
    end
  end

endmodule

@@ src/lcdde_queue.sv @@
// Two-entry queue of classified requests between front and back end.
// Depends on lcdde_pkg.
module lcdde_queue import lcdde_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       mem [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job   = mem[rd_r];
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_r ^ push;
      rd_r  <= rd_r ^ pop;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_job;
    end
  end

endmodule

@@ src/lcdde_back.sv @@
// Back end: byte sequencer that runs headers and pixel bursts part by part.
// Holds the output register; depends on lcdde_pkg.
module lcdde_back import lcdde_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  job_t head_job,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output res_t res
);

  phase_t              phase_r, phase_nxt;
  logic [3:0]          hpos_r, hpos_nxt;
  logic [15:0]         cs_r, cs_nxt, ce_r, ce_nxt, rs_r, rs_nxt, re_r, re_nxt;
  logic [PIX_W-1:0]    pix_r, pix_nxt;
  logic                low_r, low_nxt;
  logic [15:0]         color_r, color_nxt;
  logic [PART_W-1:0]   part_r, part_nxt;
  job_t                job_r, job_nxt, src;
  logic                out_valid_r;
  res_t                res_r, res_nxt;
  logic                do_search, found;
  logic [NPARTS-1:0]   mask, cand;
  logic [PART_W-1:0]   p;
  span_t               cx, ry;

  assign pop       = head_valid & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    phase_nxt = phase_r;
    hpos_nxt  = hpos_r;
    cs_nxt = cs_r; ce_nxt = ce_r; rs_nxt = rs_r; re_nxt = re_r;
    pix_nxt   = pix_r;
    low_nxt   = low_r;
    color_nxt = color_r;
    part_nxt  = part_r;
    job_nxt   = job_r;
    res_nxt   = '0;
    src       = job_r;
    do_search = 1'b0;
    for (int i = 0; i < NPARTS; i++) begin
      mask[i] = (PART_W'(i) > part_r);
    end
    if (pop) begin
      if (head_job.op == OP_PULL) begin
        if (phase_r == PH_HEADER) begin
          res_nxt.byte_valid = 1'b1;
          res_nxt.is_data    = 1'b1;
          unique case (hpos_r)
            HB_COL_CMD: begin res_nxt.byte_val = CMD_COL_SET; res_nxt.is_data = 1'b0; end
            HB_CS_HI:   res_nxt.byte_val = cs_r[15:8];
            HB_CS_LO:   res_nxt.byte_val = cs_r[7:0];
            HB_CE_HI:   res_nxt.byte_val = ce_r[15:8];
            HB_CE_LO:   res_nxt.byte_val = ce_r[7:0];
            HB_ROW_CMD: begin res_nxt.byte_val = CMD_ROW_SET; res_nxt.is_data = 1'b0; end
            HB_RS_HI:   res_nxt.byte_val = rs_r[15:8];
            HB_RS_LO:   res_nxt.byte_val = rs_r[7:0];
            HB_RE_HI:   res_nxt.byte_val = re_r[15:8];
            HB_RE_LO:   res_nxt.byte_val = re_r[7:0];
            default: begin res_nxt.byte_val = CMD_MEM_WR; res_nxt.is_data = 1'b0; end
          endcase
          hpos_nxt = hpos_r + 4'd1;
          if (hpos_r == HB_WR_CMD) begin
            phase_nxt = PH_PIXELS;
            low_nxt   = 1'b0;
            do_search = (pix_r == '0);
          end
        end else if (phase_r == PH_PIXELS) begin
          res_nxt.byte_valid = 1'b1;
          res_nxt.is_data    = 1'b1;
          if (!low_r) begin
            res_nxt.byte_val = color_r[15:8];
            low_nxt = 1'b1;
          end else begin
            res_nxt.byte_val = color_r[7:0];
            low_nxt = 1'b0;
            pix_nxt = pix_r - PIX_W'(1);
            do_search = (pix_r == PIX_W'(1));
          end
        end
      end else if ((head_job.op == OP_PIXEL || head_job.op == OP_FILL ||
                    head_job.op == OP_GLYPH || head_job.op == OP_SCALED) &&
                   phase_r == PH_IDLE) begin
        res_nxt.cmd_accepted = 1'b1;
        job_nxt   = head_job;
        src       = head_job;
        mask      = '1;
        do_search = 1'b1;
      end
    end
    cand  = src.vis & mask;
    found = 1'b0;
    p     = '0;
    for (int i = NPARTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        p     = PART_W'(i);
      end
    end
    cx = src.cols[p[5:3]];
    ry = src.rows[p[2:0]];
    if (do_search) begin
      if (found) begin
        part_nxt  = p;
        cs_nxt    = cx.start;
        ce_nxt    = cx.stop;
        rs_nxt    = ry.start;
        re_nxt    = ry.stop;
        pix_nxt   = cx.len * ry.len;
        color_nxt = src.latch[p] ? src.fg : src.bg;
        low_nxt   = 1'b0;
        hpos_nxt  = HB_COL_CMD;
        phase_nxt = PH_HEADER;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
    res_nxt.busy = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= pop | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    hpos_r  <= hpos_nxt;
    cs_r    <= cs_nxt;
    ce_r    <= ce_nxt;
    rs_r    <= rs_nxt;
    re_r    <= re_nxt;
    pix_r   <= pix_nxt;
    low_r   <= low_nxt;
    color_r <= color_nxt;
    part_r  <= part_nxt;
    job_r   <= job_nxt;
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ src/lcd_draw_command_byte_engine_top.sv @@
// Top level of the LCD draw command byte engine.
// Instantiates lcdde_front, lcdde_queue and lcdde_back; depends on lcdde_pkg.
//
// Usage: every request on the in_ channel yields exactly one result on the out_ channel,
// in order. Opcode 0 pulls the next serial byte of the display stream (column set,
// row set, memory write headers and RGB565 pixel bytes); opcodes 1 to 4 start a pixel,
// a clipped fill, a 5x7 glyph or a scaled glyph. A draw request while bytes remain is
// refused with out_cmd_accepted low. out_busy_res tells whether bytes remain after it.
// Pipeline: an accepted request passes through the first front stage (loaded at
// acceptance), the second front stage, the queue and the output register.
// Throughput: one request per cycle while neither out_stall nor in_stall is high.
// Reset (rst_n low, synchronous) empties the pipeline and the queue and returns the
// sequencer to idle. When out_stall is high the result holds, the queue fills and
// in_stall rises after it; no request is lost or repeated.
module lcd_draw_command_byte_engine_top import lcdde_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [15:0] in_rect_width,
  input  logic [15:0] in_rect_height,
  input  logic [7:0]  in_glyph_code,
  input  logic [15:0] in_fore_color,
  input  logic [15:0] in_back_color,
  input  logic [7:0]  in_glyph_scale,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_byte_valid,
  output logic        out_cmd_accepted,
  output logic        out_busy_res
);

  logic push, q_full, pop, head_valid;
  job_t push_job, head_job;
  res_t res;

  lcdde_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_pos_x, .in_pos_y,
    .in_rect_width, .in_rect_height, .in_glyph_code, .in_fore_color,
    .in_back_color, .in_glyph_scale, .push, .push_job, .q_full
  );

  lcdde_queue u_queue (
    .clk, .rst_n, .push, .push_job, .full(q_full), .pop, .head_valid, .head_job
  );

  lcdde_back u_back (
    .clk, .rst_n, .head_valid, .head_job, .pop, .out_valid, .out_stall, .res
  );

  assign out_byte         = res.byte_val;
  assign out_is_data      = res.is_data;
  assign out_byte_valid   = res.byte_valid;
  assign out_cmd_accepted = res.cmd_accepted;
  assign out_busy_res     = res.busy;

endmodule
